// ----- hdl/fpa_pkg.sv -----
// Package for the fixed-point ALU: operation codes, widths and the pipeline record.
// No dependencies.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W = 32;
    localparam int DIV_W = WORD_W + FRAC_BITS;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = (DIV_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int NUM_W = DIV_STAGES * DIV_BITS_PER_STAGE;
    // input reg, prep, divider stages, output reg
    localparam int NUM_STAGES = DIV_STAGES + 3;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
        OP_GT  = 4'd4,  OP_LT  = 4'd5,  OP_GE  = 4'd6,  OP_LE  = 4'd7,
        OP_EQ  = 4'd8,  OP_NE  = 4'd9,  OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_I2F = 4'd14, OP_F2I = 4'd15
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  a;
        logic signed [WORD_W-1:0]  b;
        logic [WORD_W-1:0]         simple;
        logic                      cmp;
        logic                      dz;
        logic                      neg;
        logic [2*WORD_W-1:0]       prod;
        logic [WORD_W:0]           rem;
        logic [NUM_W-1:0]          num;
        logic [WORD_W-1:0]         den;
    } pipe_t;

endpackage

// ----- hdl/fixed_point_alu.sv -----
// Top level of the signed fixed-point ALU (raw 32-bit words, fpa_pkg::FRAC_BITS fraction bits).
// Depends on fpa_pkg.
//
// One transaction in gives one transaction out, in order. Every operation runs
// through the same pipeline of fpa_pkg::NUM_STAGES register stages (13 at
// FRAC_BITS = 8): an input register, a prep stage that forms the 64-bit
// product, the simple results and the divider operands, one stage per four
// quotient bits of a restoring divider, and an output register that selects
// the result. A new transaction can be taken every cycle unless the full pipeline is
// stalled at the output; the divider sets the latency. Each stage holds its contents only
// while the stage after it is full and stalled, so bubbles close up and input is taken while
// a finished result waits at the output. Divide truncates toward zero; divide by zero gives 0
// with divide_by_zero set. All other results wrap to 32 bits.
module fixed_point_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]  s_axis_tuser,   // [3:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] result_raw, [32] compare_true,
                                        // [33] divide_by_zero, [39:34] zero
);

    localparam int NS = fpa_pkg::NUM_STAGES;
    localparam int F  = fpa_pkg::FRAC_BITS;
    localparam int W  = fpa_pkg::WORD_W;
    localparam int K  = fpa_pkg::DIV_BITS_PER_STAGE;

    fpa_pkg::pipe_t st_reg  [NS];
    fpa_pkg::pipe_t st_next [NS];
    logic [NS-1:0]  vld_reg;
    logic [NS:0]    adv;

    // Stage i loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NS] = m_axis_tready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    // Stage 0: capture
    always_comb
    begin
        st_next[0]        = '0;
        st_next[0].op     = fpa_pkg::op_t'(s_axis_tuser);
        st_next[0].a      = s_axis_tdata[31:0];
        st_next[0].b      = s_axis_tdata[63:32];
    end

    // Stage 1: simple ops, product, divider operands
    always_comb
    begin
        fpa_pkg::pipe_t       p;
        logic signed [W-1:0]  a;
        logic signed [W-1:0]  b;
        logic [W-1:0]         amag;
        p = st_reg[0];
        a = p.a;
        b = p.b;
        p.simple = '0;
        p.cmp    = 1'b0;
        p.dz     = 1'b0;
        case (p.op)
            fpa_pkg::OP_ADD: p.simple = a + b;
            fpa_pkg::OP_SUB: p.simple = a - b;
            fpa_pkg::OP_GT:  p.cmp = a > b;
            fpa_pkg::OP_LT:  p.cmp = a < b;
            fpa_pkg::OP_GE:  p.cmp = a >= b;
            fpa_pkg::OP_LE:  p.cmp = a <= b;
            fpa_pkg::OP_EQ:  p.cmp = a == b;
            fpa_pkg::OP_NE:  p.cmp = a != b;
            fpa_pkg::OP_MIN: p.simple = (a < b) ? a : b;
            fpa_pkg::OP_MAX: p.simple = (a < b) ? b : a;
            fpa_pkg::OP_INC: p.simple = a + W'(1);
            fpa_pkg::OP_DEC: p.simple = a - W'(1);
            fpa_pkg::OP_I2F: p.simple = a <<< F;
            fpa_pkg::OP_F2I: p.simple = a >>> F;
            fpa_pkg::OP_DIV: p.dz = (b == '0);
            default:         p.simple = '0;
        endcase
        p.prod = $signed({{W{a[W-1]}}, a}) * $signed({{W{b[W-1]}}, b});
        amag   = a[W-1] ? (~a + W'(1)) : a;
        p.den  = b[W-1] ? (~b + W'(1)) : b;
        p.neg  = a[W-1] ^ b[W-1];
        p.num  = fpa_pkg::NUM_W'({amag, {F{1'b0}}});
        p.rem  = '0;
        st_next[1] = p;
    end

    // Divider stages: K restoring steps each
    for (genvar s = 2; s < NS - 1; s++)
    begin : g_div
        always_comb
        begin
            fpa_pkg::pipe_t p;
            logic [W:0]     r;
            p = st_reg[s-1];
            for (int j = 0; j < K; j++)
            begin
                r     = {p.rem[W-1:0], p.num[fpa_pkg::NUM_W-1]};
                p.num = {p.num[fpa_pkg::NUM_W-2:0], 1'b0};
                if (r >= {1'b0, p.den})
                begin
                    r        = r - {1'b0, p.den};
                    p.num[0] = 1'b1;
                end
                p.rem = r;
            end
            st_next[s] = p;
        end
    end

    // Output stage: result select
    always_comb
    begin
        fpa_pkg::pipe_t p;
        logic [W-1:0]   q;
        p = st_reg[NS-2];
        q = p.num[W-1:0];
        case (p.op)
            fpa_pkg::OP_MUL: p.simple = p.prod[F+W-1:F];
            fpa_pkg::OP_DIV: p.simple = p.dz ? '0 : (p.neg ? (~q + W'(1)) : q);
            default:         p.simple = p.simple;
        endcase
        st_next[NS-1] = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= (i == 0) ? st_next[0] : st_next[i];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {6'b0, st_reg[NS-1].dz, st_reg[NS-1].cmp, st_reg[NS-1].simple};

    // A divide-by-zero result is zero and never a comparison.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> (m_axis_tdata[31:0] == '0) && !m_axis_tdata[32])
        else $error("divide by zero result not clean");

    // A true comparison carries a zero result word.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0)
        else $error("comparison result word not zero");

    // Input is taken whenever the first stage is empty.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_axis_tready)
        else $error("ready low with empty input stage");

endmodule
